/* design/ppp_pkg.sv */
package ppp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PT_W      = 32;
  localparam int SIZE_W    = 16;
  localparam int CLIP_W    = 64 - FRAC_BITS + 2;
  localparam int MS_W      = CLIP_W + SIZE_W;
  localparam int NUM_W     = MS_W + FRAC_BITS;
  localparam int QW        = 41;
  localparam int SX_W      = 48;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;

  localparam logic [REG_IDX_W-1:0] REG_ROW0_A     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW0_B     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW1_A     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROW1_B     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROW3_A     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ROW3_B     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_VP_ORIGIN  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_VP_SIZE    = 3'd7;

  localparam int THRESH_INT = ((1 << FRAC_BITS) + 50) / 100;
  localparam logic signed [CLIP_W-1:0] THRESH = CLIP_W'(THRESH_INT);

  typedef struct packed {
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic signed [PT_W-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic                   visible;
    logic signed [PT_W-1:0] screen_x;
    logic signed [PT_W-1:0] screen_y;
  } result_t;

  typedef logic [2:0][3:0][PT_W-1:0] mat_t;

  typedef struct packed {
    logic                     vis;
    logic signed [CLIP_W-1:0] cx;
    logic signed [CLIP_W-1:0] cy;
    logic signed [CLIP_W-1:0] w;
  } q_item_t;

endpackage

/* design/ppp_front.sv */
module ppp_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  ppp_pkg::point_t              point,
  input  ppp_pkg::mat_t                mat,
  input  logic [ppp_pkg::QCNT_W-1:0]   q_count,
  output logic                         busy,
  output logic                         push,
  output ppp_pkg::q_item_t             push_item
);

  logic                          v0;
  logic                          v1;
  ppp_pkg::point_t               pt;
  logic signed [ppp_pkg::PT_W-1:0] pc [3];
  logic signed [63:0]            prod [3][3];
  logic signed [ppp_pkg::CLIP_W-1:0] acc [3];
  logic [ppp_pkg::QCNT_W-1:0]    credit;
  logic                          take;

  assign take   = start && !busy;
  assign credit = q_count + ppp_pkg::QCNT_W'(v0) + ppp_pkg::QCNT_W'(v1);
  assign busy   = credit >= ppp_pkg::QCNT_W'(ppp_pkg::QDEPTH);

  assign pc[0] = pt.point_x;
  assign pc[1] = pt.point_y;
  assign pc[2] = pt.point_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      v0 <= take;
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pt <= point;
    end
    if (v0) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= $signed(mat[r][c]) * pc[c];
        end
      end
    end
  end

  // floor each product back to the working fraction, then add translation
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = ppp_pkg::CLIP_W'($signed(mat[r][3]));
      for (int c = 0; c < 3; c++) begin
        acc[r] = acc[r] + $signed(ppp_pkg::CLIP_W'(prod[r][c] >>> ppp_pkg::FRAC_BITS));
      end
    end
  end

  assign push           = v1;
  assign push_item.vis  = acc[2] >= ppp_pkg::THRESH;
  assign push_item.cx   = acc[0];
  assign push_item.cy   = acc[1];
  assign push_item.w    = acc[2];

endmodule

/* design/ppp_queue.sv */
module ppp_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  ppp_pkg::q_item_t            push_item,
  input  logic                        pop,
  output ppp_pkg::q_item_t            pop_item,
  output logic                        q_valid,
  output logic [ppp_pkg::QCNT_W-1:0]  count
);

  ppp_pkg::q_item_t             mem [ppp_pkg::QDEPTH];
  logic [ppp_pkg::QPTR_W-1:0]   wr_ptr;
  logic [ppp_pkg::QPTR_W-1:0]   rd_ptr;

  assign q_valid  = count != '0;
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + ppp_pkg::QCNT_W'(push) - ppp_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && count == ppp_pkg::QCNT_W'(ppp_pkg::QDEPTH)))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("queue underflow");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count lost a request");

endmodule

/* design/ppp_back.sv */
module ppp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  ppp_pkg::q_item_t  q_item,
  input  logic [31:0]       origin,
  input  logic [31:0]       size,
  output logic              pop,
  output logic              done,
  output ppp_pkg::result_t  result
);

  localparam int CW = ppp_pkg::CLIP_W;
  localparam int QW = ppp_pkg::QW;
  localparam int HW = ppp_pkg::NUM_W - QW;
  localparam logic [QW-1:0] Q_CLAMP = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    logic [CW-1:0] rem;
    logic [QW-1:0] quo;
    logic [QW-1:0] nlow;
    logic          ovf;
    logic          neg;
  } lane_t;

  typedef struct packed {
    logic          vis;
    logic [CW-1:0] den;
    lane_t         lx;
    lane_t         ly;
  } stage_t;

  logic                        v1;
  logic                        v2;
  logic                        vis1, vis2;
  logic                        negx1, negy1, negx2, negy2;
  logic [CW-1:0]               magx, magy, den1, den2;
  logic [ppp_pkg::MS_W-1:0]    msx, msy;
  stage_t                      stg [QW+1];
  stage_t                      stg0_next;
  logic [QW:0]                 vld;
  logic signed [ppp_pkg::SX_W-1:0] sx, sy;

  function automatic lane_t div_step(lane_t l, logic [CW-1:0] d);
    logic [CW:0] t;
    logic        ge;
    lane_t       o;
    t      = {l.rem, l.nlow[QW-1]};
    ge     = t >= {1'b0, d};
    o      = l;
    o.rem  = ge ? CW'(t - {1'b0, d}) : CW'(t);
    o.quo  = {l.quo[QW-2:0], ge};
    o.nlow = {l.nlow[QW-2:0], 1'b0};
    return o;
  endfunction

  function automatic lane_t div_init(logic [ppp_pkg::MS_W-1:0] ms, logic neg,
                                     logic [CW-1:0] d);
    logic [ppp_pkg::NUM_W-1:0] num;
    logic [HW-1:0]             hi;
    lane_t                     o;
    num    = {ms, {ppp_pkg::FRAC_BITS{1'b0}}};
    hi     = num[ppp_pkg::NUM_W-1:QW];
    o.ovf  = hi >= d;
    o.rem  = o.ovf ? '0 : CW'(hi);
    o.quo  = '0;
    o.nlow = num[QW-1:0];
    o.neg  = neg;
    return o;
  endfunction

  function automatic logic signed [ppp_pkg::SX_W-1:0] signed_term(lane_t l);
    logic [QW-1:0] q;
    logic signed [ppp_pkg::SX_W-1:0] s;
    q = (l.ovf || l.quo > Q_CLAMP) ? Q_CLAMP : l.quo;
    s = $signed(ppp_pkg::SX_W'(q));
    return l.neg ? -s : s;
  endfunction

  function automatic logic [31:0] sat32(logic signed [ppp_pkg::SX_W-1:0] v);
    if (v > $signed(ppp_pkg::SX_W'(32'sh7fffffff))) begin
      return 32'h7fffffff;
    end else if (v < -$signed(ppp_pkg::SX_W'(33'h080000000))) begin
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  assign pop = q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      vld <= '0;
    end else begin
      v1  <= q_valid;
      v2  <= v1;
      vld <= {vld[QW-1:0], v2};
    end
  end

  always_ff @(posedge clk) begin
    vis1  <= q_item.vis;
    negx1 <= q_item.cx[CW-1];
    negy1 <= q_item.cy[CW-1];
    magx  <= q_item.cx[CW-1] ? CW'(-q_item.cx) : CW'(q_item.cx);
    magy  <= q_item.cy[CW-1] ? CW'(-q_item.cy) : CW'(q_item.cy);
    den1  <= {q_item.w[CW-2:0], 1'b0};

    vis2  <= vis1;
    negx2 <= negx1;
    negy2 <= negy1;
    den2  <= den1;
    msx   <= ppp_pkg::MS_W'(magx) * ppp_pkg::MS_W'(size[15:0]);
    msy   <= ppp_pkg::MS_W'(magy) * ppp_pkg::MS_W'(size[31:16]);

    stg[0] <= stg0_next;
  end

  always_comb begin
    stg0_next.vis = vis2;
    stg0_next.den = den2;
    stg0_next.lx  = div_init(msx, negx2, den2);
    stg0_next.ly  = div_init(msy, negy2, den2);
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    always_ff @(posedge clk) begin
      stg[k+1].vis <= stg[k].vis;
      stg[k+1].den <= stg[k].den;
      stg[k+1].lx  <= div_step(stg[k].lx, stg[k].den);
      stg[k+1].ly  <= div_step(stg[k].ly, stg[k].den);
    end
  end

  always_comb begin
    logic signed [17:0] bx, by;
    logic signed [ppp_pkg::SX_W-1:0] half;
    bx   = 18'($signed(origin[15:0])) + $signed({3'b000, size[15:1]});
    by   = 18'($signed(origin[31:16])) + $signed({3'b000, size[31:17]});
    half = $signed(ppp_pkg::SX_W'(1) <<< (ppp_pkg::FRAC_BITS - 1));
    sx   = (ppp_pkg::SX_W'(bx) <<< ppp_pkg::FRAC_BITS) + signed_term(stg[QW].lx) + half;
    sy   = (ppp_pkg::SX_W'(by) <<< ppp_pkg::FRAC_BITS) - (signed_term(stg[QW].ly) + half);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[QW];
    end
    result.visible  <= stg[QW].vis;
    result.screen_x <= stg[QW].vis ? sat32(sx) : '0;
    result.screen_y <= stg[QW].vis ? sat32(sy) : '0;
  end

  a_done_from_pipe: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vld[QW]))
    else $error("result without request");

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.visible |-> result.screen_x == '0 && result.screen_y == '0)
    else $error("hidden point with nonzero coordinates");

  a_pop_enters: assert property (@(posedge clk) disable iff (rst)
    pop |=> v1)
    else $error("popped request lost");

endmodule

/* design/perspective_point_projection.sv */
// throughput: one point per cycle while busy is low
// a 41-stage restoring divider per axis sets the latency
// busy rises only when queued plus front-stage items reach the 4-entry queue depth,
// never in steady flow; done pulses one cycle per result; the receiver cannot stall
// synchronous active-high reset clears the configuration registers and empties the pipeline
module perspective_point_projection (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  ppp_pkg::point_t               point,
  output logic                          done,
  output ppp_pkg::result_t              result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppp_pkg::ADDR_W-1:0]    paddr,
  input  logic [ppp_pkg::DATA_W-1:0]    pwdata,
  output logic [ppp_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  logic [ppp_pkg::DATA_W-1:0]     regs [ppp_pkg::NUM_REGS];
  logic [ppp_pkg::REG_IDX_W-1:0]  idx;
  ppp_pkg::mat_t                  mat;
  logic                           push;
  logic                           pop;
  logic                           q_valid;
  ppp_pkg::q_item_t               push_item;
  ppp_pkg::q_item_t               pop_item;
  logic [ppp_pkg::QCNT_W-1:0]     q_count;

  assign pready = 1'b1;
  assign idx    = paddr[ppp_pkg::ADDR_W-1:3];
  assign prdata = regs[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ppp_pkg::NUM_REGS; i++) begin
        regs[i] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      if (idx == ppp_pkg::REG_VP_ORIGIN || idx == ppp_pkg::REG_VP_SIZE) begin
        regs[idx] <= {32'b0, pwdata[31:0]};
      end else begin
        regs[idx] <= pwdata;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        mat[r][c] = regs[ppp_pkg::REG_IDX_W'(r * 2 + (c >> 1))][(c & 1) * 32 +: 32];
      end
    end
  end

  ppp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .point     (point),
    .mat       (mat),
    .q_count   (q_count),
    .busy      (busy),
    .push      (push),
    .push_item (push_item)
  );

  ppp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_valid   (q_valid),
    .count     (q_count)
  );

  ppp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (pop_item),
    .origin  (regs[ppp_pkg::REG_VP_ORIGIN][31:0]),
    .size    (regs[ppp_pkg::REG_VP_SIZE][31:0]),
    .pop     (pop),
    .done    (done),
    .result  (result)
  );

endmodule

/* tb/tb.sv */
module tb;
  import ppp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 47;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  point_t point = '0;
  logic done;
  result_t result;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  perspective_point_projection i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // projection state mirrored from register writes
  longint mrow [3][4];
  logic [31:0] vp_origin_r, vp_size_r;

  point_t pending_points[$];
  result_t expected_results[$];
  int mismatches = 0;
  longint cycles = 0;
  int gap_left = 0;
  int burst_left = 0;

  function automatic longint floor_frac(longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic longint row_sum(int r, point_t p);
    return floor_frac(mrow[r][0] * longint'(p.point_x)) +
           floor_frac(mrow[r][1] * longint'(p.point_y)) +
           floor_frac(mrow[r][2] * longint'(p.point_z)) + mrow[r][3];
  endfunction

  function automatic longint scaled_term(longint clip, longint size, longint w);
    logic [127:0] mag, num, q;
    mag = (clip < 0) ? 128'(-clip) : 128'(clip);
    num = (mag * 128'(size)) << FRAC_BITS;
    q = num / 128'(2 * w);
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return (clip < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic result_t project(point_t p);
    result_t r;
    longint cx, cy, w, wd, ht, sx, sy;
    cx = row_sum(0, p);
    cy = row_sum(1, p);
    w = row_sum(2, p);
    r = '0;
    if (w < longint'(THRESH_INT)) return r;
    wd = longint'(vp_size_r[15:0]);
    ht = longint'(vp_size_r[31:16]);
    sx = (longint'($signed(vp_origin_r[15:0])) + (wd >> 1)) * (64'sd1 << FRAC_BITS)
         + scaled_term(cx, wd, w) + (64'sd1 << (FRAC_BITS - 1));
    sy = (longint'($signed(vp_origin_r[31:16])) + (ht >> 1)) * (64'sd1 << FRAC_BITS)
         - (scaled_term(cy, ht, w) + (64'sd1 << (FRAC_BITS - 1)));
    r.visible = 1'b1;
    r.screen_x = clamp32(sx);
    r.screen_y = clamp32(sy);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 3;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx < REG_VP_ORIGIN) begin
      mrow[idx >> 1][(idx & 1) * 2] = longint'($signed(value[31:0]));
      mrow[idx >> 1][(idx & 1) * 2 + 1] = longint'($signed(value[63:32]));
    end else if (idx == REG_VP_ORIGIN) begin
      vp_origin_r = value[31:0];
    end else begin
      vp_size_r = value[31:0];
    end
  endtask

  task automatic drain;
    while (pending_points.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 * 65536 * 40)) - 65536 * 40);
      default: return 32'($signed($urandom_range(0, 2 * 65536 * 2)) - 65536 * 2);
    endcase
  endfunction

  task automatic set_matrix(int mode);
    write_reg(REG_ROW0_A, {rand_q(mode), rand_q(mode)});
    write_reg(REG_ROW0_B, {rand_q(mode), rand_q(mode)});
    write_reg(REG_ROW1_A, {rand_q(mode), rand_q(mode)});
    write_reg(REG_ROW1_B, {rand_q(mode), rand_q(mode)});
    write_reg(REG_ROW3_A, {rand_q(2), rand_q(2)});
    write_reg(REG_ROW3_B, {32'($urandom_range(0, 65536 * 8)), rand_q(2)});
  endtask

  function automatic point_t rand_point(int mode);
    point_t p;
    p.point_x = rand_q(mode);
    p.point_y = rand_q(mode);
    p.point_z = rand_q(mode);
    return p;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (start && !busy) begin
      expected_results.push_back(project(pending_points.pop_front()));
    end
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else if (pending_points.size() != 0 && gap_left == 0) begin
      start <= 1'b1;
      point <= pending_points[0];
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end else begin
        burst_left--;
      end
    end else begin
      start <= 1'b0;
      if (gap_left > 0) gap_left--;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(result), 64'd0);
      end else begin
        result_t want;
        want = expected_results.pop_front();
        if (result.visible !== want.visible)
          report_mismatch("visible", 64'(result.visible), 64'(want.visible));
        if (result.screen_x !== want.screen_x)
          report_mismatch("screen_x", 64'(result.screen_x), 64'(want.screen_x));
        if (result.screen_y !== want.screen_y)
          report_mismatch("screen_y", 64'(result.screen_y), 64'(want.screen_y));
      end
    end
  end

  initial begin
    point_t p;
    foreach (mrow[r, c]) mrow[r][c] = 0;
    vp_origin_r = '0;
    vp_size_r = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset matrix: everything invisible
    pending_points.push_back('{32'sh7fffffff, 32'sh80000000, 32'sd0});
    drain();

    // identity-like view, unit w
    write_reg(REG_ROW0_A, {32'h0, 32'h0001_0000});
    write_reg(REG_ROW0_B, {32'h0, 32'h0});
    write_reg(REG_ROW1_A, {32'h0001_0000, 32'h0});
    write_reg(REG_ROW1_B, {32'h0, 32'h0});
    write_reg(REG_ROW3_A, {32'h0, 32'h0});
    write_reg(REG_ROW3_B, {32'h0001_0000, 32'h0});
    write_reg(REG_VP_ORIGIN, {16'sh8000, 16'sh7fff});
    write_reg(REG_VP_SIZE, {16'hffff, 16'hffff});
    pending_points.push_back('{32'sh7fffffff, 32'sh7fffffff, 32'sh0001_0000});
    pending_points.push_back('{32'sh80000000, 32'sh80000000, 32'sh0001_0000});
    pending_points.push_back('{32'sd0, 32'sd0, 32'sd655});
    pending_points.push_back('{32'sd0, 32'sd0, 32'sd654});
    pending_points.push_back('{32'sd1, -32'sd1, 32'sd656});
    pending_points.push_back('{32'sh0000_8000, -32'sh0000_8000, 32'sh0001_0000});
    pending_points.push_back('{32'sd0, 32'sd0, -32'sh0001_0000});
    pending_points.push_back('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff});
    pending_points.push_back('{32'sh0, 32'sh0, 32'sh0});
    drain();
    write_reg(REG_VP_ORIGIN, '0);
    write_reg(REG_VP_SIZE, {16'd480, 16'd640});
    pending_points.push_back('{32'sh0000_4000, 32'sh0000_4000, 32'sh0002_0000});
    pending_points.push_back('{-32'sh0000_4000, 32'sh0010_0000, 32'sh0000_0400});
    pending_points.push_back('{32'sh12345678, -32'sh7654321, 32'sd655});
    drain();
    write_reg(REG_VP_SIZE, '0);
    pending_points.push_back('{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000});

    for (int phase = 0; phase < 12; phase++) begin
      drain();
      set_matrix(phase % 3);
      write_reg(REG_VP_ORIGIN, (phase == 5) ? 32'h8000_8000 : $urandom());
      write_reg(REG_VP_SIZE, (phase == 7) ? 32'hffff_ffff :
                (phase == 9) ? 32'h0 : $urandom());
      for (int n = 0; n < 150; n++) begin
        p = rand_point(($urandom_range(0, 3) == 0) ? 0 : 1 + (n & 1));
        pending_points.push_back(p);
      end
    end
    drain();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ppp_pkg.sv
design/ppp_front.sv
design/ppp_queue.sv
design/ppp_back.sv
design/perspective_point_projection.sv
tb/tb.sv
